// File: hw/rtl/sgps_pkg.sv
// Shared types and constants for the grid-line segment splitter.
// Field widths, register indexes and stream packing offsets.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgps_pkg;

    localparam int ID_W      = 20;
    localparam int COORD_W   = 32;
    localparam int MARK_W    = 16;
    localparam int PLANES    = 4;
    localparam int PIDX_W    = 2;
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 2;
    localparam int ADDR_W    = 5;
    localparam int STEPS     = 33;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [2:0] {
        REG_SPLIT_AXIS   = 3'd0,
        REG_PLANE_COUNT  = 3'd1,
        REG_PLANE_0      = 3'd2,
        REG_PLANE_1      = 3'd3,
        REG_PLANE_2      = 3'd4,
        REG_PLANE_3      = 3'd5,
        REG_POINT_BASE   = 3'd6,
        REG_SEGMENT_BASE = 3'd7
    } reg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/segment_grid_plane_splitter_core.sv
// Splits a 2D segment at up to four axis-aligned grid lines, one piece per transfer.
// Uses sgps_pkg for widths, register indexes and constants.
//
//  channel | dir | content
//  s_*     | in  | s_tdata: segment_id, end_a_id, end_b_id, end_a_x, end_a_y,
//          |     |          end_b_x, end_b_y, boundary_marker
//  m_*     | out | m_tdata: piece fields; m_tuser: new_point_valid, id_overflow;
//          |     | m_tlast: last_piece
//  apb     | in  | eight registers at byte address 4*i
//
// A segment with no crossing passes through order, one bin step per active plane,
// difference, emit and the output transfer. Each crossing is setup, clamp,
// 33 shift-add multiply steps, 33 restoring divide steps, emit and the output transfer;
// the multiply and divide steps share the one 34-bit add/subtract unit. s_tready is high only when the sequencer is
// idle. While m_tready is low the sequencer waits in its hold state. Reset clears the control state and
// loads the id counters with zero.
`timescale 1ns / 1ps
`default_nettype none

module segment_grid_plane_splitter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [19:0] segment_id, [39:20] end_a_id, [59:40] end_b_id, [91:60] end_a_x,
    // [123:92] end_a_y, [155:124] end_b_x, [187:156] end_b_y,
    // [203:188] boundary_marker, [207:204] zero
    input  wire logic [sgps_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [19:0] piece_segment_id, [39:20] piece_start_point, [59:40] piece_end_point,
    // [75:60] piece_marker, [107:76] new_point_x, [139:108] new_point_y,
    // [143:140] zero
    output logic [sgps_pkg::OUT_DATA_W-1:0]        m_tdata,
    // [0] new_point_valid, [1] id_overflow
    output logic [sgps_pkg::OUT_USER_W-1:0]        m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sgps_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_ORDER, S_BIN, S_DIFF, S_SETUP, S_CLAMP, S_MUL, S_DIV, S_EMIT, S_HOLD
    } state_t;

    localparam int CW = sgps_pkg::COORD_W;
    localparam int IW = sgps_pkg::ID_W;

    state_t state_reg;

    logic                              axis_reg;
    logic [2:0]                        pcount_reg;
    logic signed [CW-1:0]              planes_reg [sgps_pkg::PLANES];
    logic [IW-1:0]                     pt_base_reg;
    logic [IW-1:0]                     seg_base_reg;
    logic [IW-1:0]                     pt_ctr_reg;
    logic [IW-1:0]                     seg_ctr_reg;

    logic [IW-1:0]                     sid_reg, ida_reg, idb_reg;
    logic signed [CW-1:0]              ax_reg, ay_reg, bx_reg, by_reg;
    logic [sgps_pkg::MARK_W-1:0]       mk_reg;

    logic signed [CW-1:0]              c1_reg, c2_reg, o1_reg, o2_reg;
    logic [IW-1:0]                     lo_id_reg, hi_id_reg, prev_reg;
    logic [2:0]                        n_reg, p0_reg, p1_reg, k_reg, delta_reg;
    logic                              f0_reg, f1_reg;
    logic [sgps_pkg::PIDX_W-1:0]       bidx_reg;
    logic [CW:0]                       den_reg;
    logic signed [CW:0]                d_reg;
    logic [CW:0]                       mag_reg;
    logic signed [CW:0]                t_reg;
    logic [2*CW+1:0]                   prod_reg;
    logic [CW:0]                       rem_reg;
    logic [5:0]                        cnt_reg;

    logic                              out_valid_reg;
    logic [sgps_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [sgps_pkg::OUT_USER_W-1:0]   out_user_reg;
    logic                              out_last_reg;

    logic signed [CW-1:0]              ka, kb, pl_bin, pl_cur, other;
    logic [2:0]                        pidx_sum;
    logic                              cfg_wr;
    logic                              alu_sub;
    logic [CW+1:0]                     alu_a, alu_b, alu_sum;
    logic [CW+1:0]                     mul_sum;
    logic [CW+1:0]                     div_rem;
    logic                              div_ge;
    logic                              seg_full, pt_full, first_piece;
    logic [IW-1:0]                     seg_id_new, pt_id_new, psid;
    logic                              ovf;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        ka       = axis_reg ? ay_reg : ax_reg;
        kb       = axis_reg ? by_reg : bx_reg;
        pl_bin   = planes_reg[bidx_reg];
        pidx_sum = p0_reg + k_reg;
        pl_cur   = planes_reg[pidx_sum[sgps_pkg::PIDX_W-1:0]];
        // one shared 34-bit adder: multiply accumulates, divide trial-subtracts
        alu_sub  = (state_reg == S_DIV);
        alu_a    = alu_sub ? {rem_reg, prod_reg[CW]} : {1'b0, prod_reg[2*CW+1:CW+1]};
        alu_b    = {1'b0, alu_sub ? den_reg : mag_reg};
        alu_sum  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
        mul_sum  = alu_sum;
        div_rem  = alu_sum;
        div_ge   = !div_rem[CW+1];
        other    = d_reg[CW] ? (o1_reg - prod_reg[CW-1:0]) : (o1_reg + prod_reg[CW-1:0]);
        seg_full = (seg_ctr_reg == sgps_pkg::ID_MAX);
        pt_full  = (pt_ctr_reg == sgps_pkg::ID_MAX);
        seg_id_new  = seg_full ? sgps_pkg::ID_MAX : seg_ctr_reg + 1'b1;
        pt_id_new   = pt_full ? sgps_pkg::ID_MAX : pt_ctr_reg + 1'b1;
        first_piece = (k_reg == 3'd0);
        psid        = first_piece ? sid_reg : seg_id_new;
    end

    always_comb
    begin
        prdata = '0;
        unique case (sgps_pkg::reg_idx_t'(paddr[4:2]))
            sgps_pkg::REG_SPLIT_AXIS:   prdata = {31'd0, axis_reg};
            sgps_pkg::REG_PLANE_COUNT:  prdata = {29'd0, pcount_reg};
            sgps_pkg::REG_PLANE_0:      prdata = planes_reg[0];
            sgps_pkg::REG_PLANE_1:      prdata = planes_reg[1];
            sgps_pkg::REG_PLANE_2:      prdata = planes_reg[2];
            sgps_pkg::REG_PLANE_3:      prdata = planes_reg[3];
            sgps_pkg::REG_POINT_BASE:   prdata = {{(32-IW){1'b0}}, pt_base_reg};
            sgps_pkg::REG_SEGMENT_BASE: prdata = {{(32-IW){1'b0}}, seg_base_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            pcount_reg    <= 3'd1;
            for (int i = 0; i < sgps_pkg::PLANES; i++)
            begin
                planes_reg[i] <= '0;
            end
            pt_base_reg   <= '0;
            seg_base_reg  <= '0;
            pt_ctr_reg    <= '0;
            seg_ctr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (sgps_pkg::reg_idx_t'(paddr[4:2]))
                    sgps_pkg::REG_SPLIT_AXIS:  axis_reg      <= pwdata[0];
                    sgps_pkg::REG_PLANE_COUNT: pcount_reg    <= pwdata[2:0];
                    sgps_pkg::REG_PLANE_0:     planes_reg[0] <= pwdata;
                    sgps_pkg::REG_PLANE_1:     planes_reg[1] <= pwdata;
                    sgps_pkg::REG_PLANE_2:     planes_reg[2] <= pwdata;
                    sgps_pkg::REG_PLANE_3:     planes_reg[3] <= pwdata;
                    sgps_pkg::REG_POINT_BASE:
                    begin
                        pt_base_reg <= pwdata[IW-1:0];
                        pt_ctr_reg  <= pwdata[IW-1:0];
                    end
                    sgps_pkg::REG_SEGMENT_BASE:
                    begin
                        seg_base_reg <= pwdata[IW-1:0];
                        seg_ctr_reg  <= pwdata[IW-1:0];
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sid_reg   <= s_tdata[19:0];
                        ida_reg   <= s_tdata[39:20];
                        idb_reg   <= s_tdata[59:40];
                        ax_reg    <= s_tdata[91:60];
                        ay_reg    <= s_tdata[123:92];
                        bx_reg    <= s_tdata[155:124];
                        by_reg    <= s_tdata[187:156];
                        mk_reg    <= s_tdata[203:188];
                        state_reg <= S_ORDER;
                    end
                end
                S_ORDER:
                begin
                    // strictly smaller end is low; on a tie end_b is low
                    if (ka < kb)
                    begin
                        c1_reg <= ka; c2_reg <= kb;
                        lo_id_reg <= ida_reg; hi_id_reg <= idb_reg;
                        o1_reg <= axis_reg ? ax_reg : ay_reg;
                        o2_reg <= axis_reg ? bx_reg : by_reg;
                    end
                    else
                    begin
                        c1_reg <= kb; c2_reg <= ka;
                        lo_id_reg <= idb_reg; hi_id_reg <= ida_reg;
                        o1_reg <= axis_reg ? bx_reg : by_reg;
                        o2_reg <= axis_reg ? ax_reg : ay_reg;
                    end
                    n_reg     <= (pcount_reg > 3'd4) ? 3'd4 : pcount_reg;
                    p0_reg    <= (pcount_reg > 3'd4) ? 3'd4 : pcount_reg;
                    p1_reg    <= (pcount_reg > 3'd4) ? 3'd4 : pcount_reg;
                    f0_reg    <= 1'b0;
                    f1_reg    <= 1'b0;
                    bidx_reg  <= '0;
                    state_reg <= (pcount_reg == 3'd0) ? S_DIFF : S_BIN;
                end
                S_BIN:
                begin
                    if (!f0_reg && (c1_reg <= pl_bin))
                    begin
                        p0_reg <= {1'b0, bidx_reg};
                        f0_reg <= 1'b1;
                    end
                    if (!f1_reg && (c2_reg <= pl_bin))
                    begin
                        p1_reg <= {1'b0, bidx_reg};
                        f1_reg <= 1'b1;
                    end
                    if ({1'b0, bidx_reg} == n_reg - 3'd1)
                    begin
                        state_reg <= S_DIFF;
                    end
                    bidx_reg <= bidx_reg + 1'b1;
                end
                S_DIFF:
                begin
                    den_reg   <= (CW+1)'(c2_reg) - (CW+1)'(c1_reg);
                    d_reg     <= (CW+1)'(o2_reg) - (CW+1)'(o1_reg);
                    delta_reg <= (p1_reg > p0_reg) ? p1_reg - p0_reg : 3'd0;
                    k_reg     <= 3'd0;
                    prev_reg  <= lo_id_reg;
                    state_reg <= (p1_reg > p0_reg) ? S_SETUP : S_EMIT;
                end
                S_SETUP:
                begin
                    if (k_reg == delta_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        t_reg     <= (CW+1)'(pl_cur) - (CW+1)'(c1_reg);
                        mag_reg   <= d_reg[CW] ? (CW+1)'(-d_reg) : (CW+1)'(d_reg);
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    // clamp t to [0, den]; product register starts with t in the low half
                    if (t_reg[CW])
                        prod_reg <= '0;
                    else if ((CW+1)'(t_reg) > den_reg)
                        prod_reg <= {(CW+1)'(0), den_reg};
                    else
                        prod_reg <= {(CW+1)'(0), (CW+1)'(t_reg)};
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (prod_reg[0])
                        prod_reg <= {mul_sum, prod_reg[CW:1]};
                    else
                        prod_reg <= {1'b0, prod_reg[2*CW+1:1]};
                    if (cnt_reg == 6'(sgps_pkg::STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                        // quotient fits 33 bits, so the high half is already below den
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_ge)
                        rem_reg <= div_rem[CW:0];
                    else
                        rem_reg <= {rem_reg[CW-1:0], prod_reg[CW]};
                    prod_reg[CW:0] <= {prod_reg[CW-1:0], div_ge};
                    if (cnt_reg == 6'(sgps_pkg::STEPS - 1))
                        state_reg <= S_EMIT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_HOLD;
                    if (delta_reg == 3'd0)
                    begin
                        out_data_reg <= {4'd0, 32'd0, 32'd0, mk_reg, idb_reg, ida_reg, sid_reg};
                        out_user_reg <= 2'b00;
                        out_last_reg <= 1'b1;
                    end
                    else if (k_reg == delta_reg)
                    begin
                        seg_ctr_reg  <= seg_id_new;
                        out_data_reg <= {4'd0, 32'd0, 32'd0, mk_reg, hi_id_reg, prev_reg, psid};
                        out_user_reg <= {seg_full, 1'b0};
                        out_last_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!first_piece)
                            seg_ctr_reg <= seg_id_new;
                        pt_ctr_reg   <= pt_id_new;
                        prev_reg     <= pt_id_new;
                        out_data_reg <= {4'd0,
                                         axis_reg ? pl_cur : other,
                                         axis_reg ? other : pl_cur,
                                         mk_reg, pt_id_new, prev_reg, psid};
                        out_user_reg <= {ovf, 1'b1};
                        out_last_reg <= 1'b0;
                    end
                end
                S_HOLD:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= S_SETUP;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // high half of the finished product seeds the divider remainder
            if (state_reg == S_MUL && cnt_reg == 6'(sgps_pkg::STEPS - 1))
            begin
                rem_reg <= prod_reg[0] ? mul_sum[CW+1:1] : {1'b0, prod_reg[2*CW+1:CW+2]};
            end
        end
    end

    assign ovf = (!first_piece && seg_full) || pt_full;

endmodule

`default_nettype wire
